// ===== rtl/slt_pkg.sv =====
`timescale 1ns / 1ps

package slt_pkg;

    localparam int CAPACITY   = 16;
    localparam int ATTRS      = 4;
    localparam int ROW_FIELDS = 4;
    localparam int DATA_W     = 32;
    localparam int OCC_W      = 5;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FINISH
    } state_e;

    typedef logic [ATTRS-1:0][DATA_W-1:0]      attrs_t;
    typedef logic [ROW_FIELDS-1:0][DATA_W-1:0] row_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        attrs_t            row;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        status_e          status;
        row_t             row;
        logic [CNT_W-1:0] fill;
    } result_t;

endpackage

// ===== rtl/sorted_leaf_table.sv =====
`timescale 1ns / 1ps

// sorted table of up to 16 entries, each a 32-bit key and a row of four 32-bit
// attributes, kept in ascending key order in a single-port-write memory. every
// item (insert, remove, lookup, unused op code) gives exactly one result item
// with a status, the looked-up row (zero otherwise) and the occupancy after the
// operation. an item is handled by a small sequencer around a key less-than
// and a key equality compare: a linear scan reads one entry per cycle until the
// lower-bound position p, then an insert or remove moves one entry per cycle
// through the memory, s entries in all. p + s never exceeds 15 for a change and
// p never exceeds 16 for a scan; the registered memory read sets the
// one-entry-per-cycle pace.
// in_ready is high only while the sequencer is idle; a finished result sits in
// an output register, so the next item can be taken while it waits.

module sorted_leaf_table
    import slt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] value_0,
    input  logic [DATA_W-1:0] value_1,
    input  logic [DATA_W-1:0] value_2,
    input  logic [DATA_W-1:0] value_3,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [DATA_W-1:0] row_0,
    output logic [DATA_W-1:0] row_1,
    output logic [DATA_W-1:0] row_2,
    output logic [DATA_W-1:0] row_3,
    output logic [OCC_W-1:0]  occupancy
);

    row_t     in_row;
    attrs_t   in_attrs;
    entry_t   rd_data;
    mem_req_t mem_req;
    logic     res_valid;
    result_t  result;
    logic     out_free;

    logic             out_valid_reg;
    status_e          status_reg;
    row_t             row_reg;
    logic [OCC_W-1:0] occ_reg;

    // only the first ATTRS values of an item are stored
    assign in_row = {value_3, value_2, value_1, value_0};

    always_comb
    begin
        in_attrs = '0;
        for (int a = 0; a < ATTRS; a++)
        begin
            in_attrs[a] = in_row[a];
        end
    end

    slt_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    slt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .in_key    (key),
        .in_attrs  (in_attrs),
        .rd_data   (rd_data),
        .mem_req   (mem_req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .result    (result)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            status_reg <= result.status;
            row_reg    <= result.row;
            occ_reg    <= OCC_W'(result.fill);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign row_0     = row_reg[0];
    assign row_1     = row_reg[1];
    assign row_2     = row_reg[2];
    assign row_3     = row_reg[3];
    assign occupancy = occ_reg;

endmodule

// ===== rtl/slt_store.sv =====
`timescale 1ns / 1ps

module slt_store
    import slt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// ===== rtl/slt_ctrl.sv =====
`timescale 1ns / 1ps

module slt_ctrl
    import slt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_op,
    input  logic [DATA_W-1:0] in_key,
    input  attrs_t            in_attrs,
    input  entry_t            rd_data,
    output mem_req_t          mem_req,
    input  logic              out_free,
    output logic              res_valid,
    output result_t           result
);

    state_e            state_reg, state_next;
    op_e               op_reg, op_next;
    logic [DATA_W-1:0] key_reg, key_next;
    attrs_t            attrs_reg, attrs_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    status_e           status_reg, status_next;
    row_t              row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        attrs_reg  <= attrs_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        row_reg    <= row_next;
    end

    always_comb
    begin
        logic [CNT_W-1:0] idx_inc;
        logic [CNT_W-1:0] idx_inc2;
        logic [CNT_W-1:0] idx_dec2;
        logic [CNT_W-1:0] fill_dec;
        logic             below_fill;
        logic             hit;

        idx_inc    = idx_reg + CNT_W'(1);
        idx_inc2   = idx_reg + CNT_W'(2);
        idx_dec2   = idx_reg - CNT_W'(2);
        fill_dec   = fill_reg - CNT_W'(1);
        below_fill = (idx_reg < fill_reg);
        hit        = below_fill && (rd_data.key == key_reg);

        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        attrs_next  = attrs_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        status_next = status_reg;
        row_next    = row_reg;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = idx_reg[IDX_W-1:0];
        mem_req.wr_data = '{key: key_reg, row: attrs_reg};
        mem_req.rd_addr = idx_reg[IDX_W-1:0];

        in_ready  = 1'b0;
        res_valid = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = op_e'(in_op);
                    key_next    = in_key;
                    attrs_next  = in_attrs;
                    status_next = ST_OK;
                    row_next    = '0;
                    idx_next    = '0;
                    mem_req.rd_addr = '0;
                    if (op_e'(in_op) == OP_NOP)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            // linear lower-bound scan, one entry per cycle
            S_SEARCH:
            begin
                if (below_fill && (rd_data.key < key_reg))
                begin
                    idx_next        = idx_inc;
                    mem_req.rd_addr = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    pos_next = idx_reg;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (hit)
                            begin
                                status_next = ST_DUP;
                                state_next  = S_FINISH;
                            end
                            else if (fill_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                idx_next        = fill_reg;
                                mem_req.rd_addr = fill_dec[IDX_W-1:0];
                                state_next      = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit)
                            begin
                                status_next = ST_NOTFOUND;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                mem_req.rd_addr = idx_inc[IDX_W-1:0];
                                state_next      = S_SHIFT_DN;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (!hit)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                for (int a = 0; a < ATTRS; a++)
                                begin
                                    row_next[a] = rd_data.row[a];
                                end
                            end
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // move entries up from the top, then drop the new one in at pos
            S_SHIFT_UP:
            begin
                mem_req.wr_en = 1'b1;
                if (idx_reg == pos_reg)
                begin
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_req.wr_data = rd_data;
                    idx_next        = idx_reg - CNT_W'(1);
                    mem_req.rd_addr = idx_dec2[IDX_W-1:0];
                end
            end

            // close the gap left by the removed entry
            S_SHIFT_DN:
            begin
                if (idx_inc >= fill_reg)
                begin
                    fill_next  = fill_dec;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = rd_data;
                    idx_next        = idx_inc;
                    mem_req.rd_addr = idx_inc2[IDX_W-1:0];
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result = '{status: status_reg, row: row_reg, fill: fill_reg};

endmodule

// ===== tb/sv/sorted_table_tracker_pkg.sv =====
`timescale 1ns / 1ps

package sorted_table_tracker_pkg;

    import slt_pkg::*;

    typedef struct packed {
        status_e          status;
        row_t             row;
        logic [OCC_W-1:0] occupancy;
    } table_answer_t;

    class sorted_table_tracker;

        logic [DATA_W-1:0] keys [CAPACITY];
        row_t              rows [CAPACITY];
        int unsigned       fill;
        table_answer_t     pending_answers [$];
        int unsigned       mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // first position whose key is not below k
        function int unsigned lower_bound(input logic [DATA_W-1:0] k);
            int unsigned i;
            i = 0;
            while (i < fill && keys[i] < k)
                i++;
            return i;
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction

        function logic [DATA_W-1:0] stored_key(input int unsigned idx);
            return keys[idx];
        endfunction

        // apply one accepted item to the shadow table and queue its answer
        function void note_request(input logic [1:0] op_code, input logic [DATA_W-1:0] k,
                                   input row_t values);
            table_answer_t ans;
            int unsigned   pos;
            int unsigned   j;
            int unsigned   a;
            bit            hit;
            pos        = lower_bound(k);
            hit        = (pos < fill) && (keys[pos] == k);
            ans.status = ST_OK;
            ans.row    = '0;
            case (op_e'(op_code))
                OP_INSERT:
                begin
                    if (hit)
                        ans.status = ST_DUP;
                    else if (fill >= CAPACITY)
                        ans.status = ST_FULL;
                    else
                    begin
                        for (j = fill; j > pos; j--)
                        begin
                            keys[j] = keys[j - 1];
                            rows[j] = rows[j - 1];
                        end
                        keys[pos] = k;
                        rows[pos] = '0;
                        for (a = 0; a < ATTRS; a++)
                            rows[pos][a] = values[a];
                        fill++;
                    end
                end
                OP_REMOVE:
                begin
                    if (!hit)
                        ans.status = ST_NOTFOUND;
                    else
                    begin
                        for (j = pos; j + 1 < fill; j++)
                        begin
                            keys[j] = keys[j + 1];
                            rows[j] = rows[j + 1];
                        end
                        fill--;
                    end
                end
                OP_LOOKUP:
                begin
                    if (!hit)
                        ans.status = ST_NOTFOUND;
                    else
                        for (a = 0; a < ATTRS; a++)
                            ans.row[a] = rows[pos][a];
                end
                default:
                begin
                end
            endcase
            ans.occupancy = OCC_W'(fill);
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(input logic [1:0] st, input row_t row,
                                   input logic [OCC_W-1:0] occ);
            table_answer_t exp_ans;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: status %0d row %h occupancy %0d",
                             st, row, occ);
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (st !== exp_ans.status || row !== exp_ans.row || occ !== exp_ans.occupancy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d row %h occupancy %0d, got status %0d row %h occupancy %0d",
                             exp_ans.status, exp_ans.row, exp_ans.occupancy, st, row, occ);
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/sorted_leaf_table_test.sv =====
`timescale 1ns / 1ps

module sorted_leaf_table_test;

    import slt_pkg::*;
    import sorted_table_tracker_pkg::*;

    // random items per idling phase, four phases
    localparam int PHASE_ITEMS = 460;
    // wait at the end longer than the slowest item takes
    localparam int TAIL_CYCLES = 40;
    localparam int POOL_SIZE   = 24;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        op        = '0;
    logic [DATA_W-1:0] key       = '0;
    logic [DATA_W-1:0] value_0   = '0;
    logic [DATA_W-1:0] value_1   = '0;
    logic [DATA_W-1:0] value_2   = '0;
    logic [DATA_W-1:0] value_3   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [DATA_W-1:0] row_0;
    logic [DATA_W-1:0] row_1;
    logic [DATA_W-1:0] row_2;
    logic [DATA_W-1:0] row_3;
    logic [OCC_W-1:0]  occupancy;

    // percent of cycles the sender idles / the receiver stalls
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    sorted_table_tracker tracker;

    // small key pool so inserts collide and removes and lookups hit
    logic [DATA_W-1:0] key_pool [POOL_SIZE];

    sorted_leaf_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .key       (key),
        .value_0   (value_0),
        .value_1   (value_1),
        .value_2   (value_2),
        .value_3   (value_3),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .row_0     (row_0),
        .row_1     (row_1),
        .row_2     (row_2),
        .row_3     (row_3),
        .occupancy (occupancy)
    );

    initial
    begin
        forever
            #6 clk = ~clk;
    end

    // receiver: ready changes on the falling edge only
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_answer(status, {row_3, row_2, row_1, row_0}, occupancy);
    end

    // mostly full-range words, now and then the all-zero and all-one extremes
    function automatic logic [DATA_W-1:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        return $urandom;
    endfunction

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_item(input logic [1:0] op_code, input logic [DATA_W-1:0] k,
                             input row_t values);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_code;
        key      <= k;
        value_0  <= values[0];
        value_1  <= values[1];
        value_2  <= values[2];
        value_3  <= values[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_request(op_code, k, values);
        @(negedge clk);
    endtask

    // hold off the sender until every queued answer has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic run_directed();
        row_t          vals;
        int unsigned   i;
        // empty table: lookup and remove miss
        vals = {random_word(), random_word(), random_word(), random_word()};
        send_item(OP_LOOKUP, 32'h0000_1234, vals);
        send_item(OP_REMOVE, 32'h0000_1234, vals);
        // insert up to capacity, out of order so entries get shifted up
        send_item(OP_INSERT, 32'h8000_0000, vals);
        send_item(OP_INSERT, 32'hFFFF_FFFF, '1);
        send_item(OP_INSERT, 32'h0000_0000, '0);
        for (i = 0; i < CAPACITY - 3; i++)
        begin
            vals = {random_word(), random_word(), random_word(), random_word()};
            send_item(OP_INSERT, random_word() | 32'h1, vals);
        end
        // new key is refused when the table is full, a present key still reports duplicate
        send_item(OP_INSERT, 32'h8000_0002, vals);
        send_item(OP_INSERT, 32'h8000_0000, vals);
        send_item(OP_LOOKUP, 32'h0000_0000, vals);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, vals);
        send_item(OP_LOOKUP, 32'h8000_0002, vals);
        // remove last and first, then miss
        send_item(OP_REMOVE, 32'hFFFF_FFFF, vals);
        send_item(OP_REMOVE, 32'h0000_0000, vals);
        send_item(OP_REMOVE, 32'h8000_0002, vals);
        // unused op code leaves the table alone
        send_item(OP_NOP, 32'h8000_0000, vals);
    endtask

    task automatic run_random(input int unsigned count);
        row_t             vals;
        logic [DATA_W-1:0] k;
        logic [1:0]       op_code;
        int unsigned      n;
        int unsigned      r;
        int unsigned      ins_weight;
        int unsigned      rest;
        for (n = 0; n < count; n++)
        begin
            // alternate insert-heavy and remove-heavy stretches so the fill
            // level swings between empty and full
            ins_weight = ((n / 50) % 2 == 0) ? 65 : 30;
            rest       = 95 - ins_weight;
            r          = $urandom_range(0, 99);
            if (r < ins_weight)
                op_code = OP_INSERT;
            else if (r < ins_weight + rest / 2)
                op_code = OP_REMOVE;
            else if (r < 95)
                op_code = OP_LOOKUP;
            else
                op_code = OP_NOP;
            // key: one already stored, one from the pool, or anything
            r = $urandom_range(0, 99);
            if (r < 35 && tracker.fill > 0)
                k = tracker.stored_key($urandom_range(0, tracker.fill - 1));
            else if (r < 80)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = random_word();
            vals = {random_word(), random_word(), random_word(), random_word()};
            send_item(op_code, k, vals);
        end
    endtask

    // generous limit, far beyond the slowest legal run
    initial
    begin
        #(10_000_000);
        $display("sorted_leaf_table verification failed");
        $finish;
    end

    initial
    begin
        int unsigned p;
        tracker = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (p = 2; p < POOL_SIZE; p++)
            key_pool[p] = $urandom;

        // single reset at the start of the run
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        drain_results();

        // idling phases: none, sender only, receiver only, both
        run_random(PHASE_ITEMS);
        drain_results();
        idle_pct = 52;
        run_random(PHASE_ITEMS);
        drain_results();
        idle_pct  = 0;
        stall_pct = 52;
        run_random(PHASE_ITEMS);
        drain_results();
        idle_pct  = 32;
        stall_pct = 32;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("sorted_leaf_table verification clean");
        else
            $display("sorted_leaf_table verification failed");
        $finish;
    end

endmodule
